/* sv/mpsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared types and constants of the multitap pitch shift delay.
// ----------------------------------------------------------------------------
package mpsd_pkg;

    localparam int LINE_DEPTH_DEF = 8192;
    localparam int MAX_TAPS_DEF   = 8;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int LL_W       = 14;
    localparam int TS_W       = 13;
    localparam int TC_W       = 4;
    localparam int RS_W       = 18;
    localparam int ES_W       = 25;
    localparam int FG_W       = 16;
    localparam int OS_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [LL_W-1:0] LL_RST = 14'd2160;
    localparam logic [TS_W-1:0] TS_RST = 13'd1080;
    localparam logic [TC_W-1:0] TC_RST = 4'd2;
    localparam logic [RS_W-1:0] RS_RST = 18'd131072;
    localparam logic [ES_W-1:0] ES_RST = 25'd15534;
    localparam logic [FG_W-1:0] FG_RST = 16'd0;
    localparam logic [OS_W-1:0] OS_RST = 16'd8192;

    localparam logic [ES_W-1:0] WEIGHT_MAX = 25'h100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LENGTH    = 3'd0,
        CFG_TAP_SPACING    = 3'd1,
        CFG_TAP_COUNT      = 3'd2,
        CFG_READ_STEP      = 3'd3,
        CFG_ENVELOPE_SLOPE = 3'd4,
        CFG_FEEDBACK_GAIN  = 3'd5,
        CFG_OUTPUT_SCALE   = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_DIV_STEP,
        OP_SET_RPI,
        OP_SET_SPM,
        OP_RDA,
        OP_RDB,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_ACC,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3,
        OP_SET_RP,
        OP_OUT_LOAD
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_RP,
        ST_SET_RPI,
        ST_DIV_SP,
        ST_SET_SPM,
        ST_TAP_A,
        ST_TAP_B,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ACC,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_DIV_NRP,
        ST_SET_RP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic tap_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* sv/multitap_pitch_shift_delay.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multitap_pitch_shift_delay
// Delay line pitch shifter with crossfaded interpolating taps.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  sample_in
//   output   out        out_valid / out_stall sample_out
//   config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request at a time; the work is paced by the bit-serial remainder unit
// (14 bits wide at default depth) and the single read port of the line.
// After reset a clearing pass zeroes all LINE_DEPTH (8192) entries of the line;
// no request is taken meanwhile. Config writes are taken at any time.
// A waiting result sits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module multitap_pitch_shift_delay #(
    parameter int LINE_DEPTH = mpsd_pkg::LINE_DEPTH_DEF,
    parameter int MAX_TAPS   = mpsd_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [mpsd_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [mpsd_pkg::SAMPLE_W-1:0]       sample_out,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mpsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mpsd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    mpsd_pkg::cmd_t    cmd;
    mpsd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mpsd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mpsd_datapath #(
        .LINE_DEPTH (LINE_DEPTH),
        .MAX_TAPS   (MAX_TAPS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule
`default_nettype wire

/* sv/mpsd_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsd_controller
// Sequencer: clearing pass, pointer reduction, per-tap steps, finish, emit.
// ----------------------------------------------------------------------------
module mpsd_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire mpsd_pkg::status_t status,
    output mpsd_pkg::cmd_t        cmd
);

    mpsd_pkg::state_t state_reg;
    mpsd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpsd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mpsd_pkg::OP_NONE;
        in_stall   = 1'b1;
        unique case (state_reg)
            mpsd_pkg::ST_CLEAR:
            begin
                cmd.op = mpsd_pkg::OP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = mpsd_pkg::ST_IDLE;
                end
            end
            mpsd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = mpsd_pkg::OP_START;
                    state_next = mpsd_pkg::ST_DIV_RP;
                end
            end
            mpsd_pkg::ST_DIV_RP:
            begin
                cmd.op = mpsd_pkg::OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = mpsd_pkg::ST_SET_RPI;
                end
            end
            mpsd_pkg::ST_SET_RPI:
            begin
                cmd.op     = mpsd_pkg::OP_SET_RPI;
                state_next = mpsd_pkg::ST_DIV_SP;
            end
            mpsd_pkg::ST_DIV_SP:
            begin
                cmd.op = mpsd_pkg::OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = mpsd_pkg::ST_SET_SPM;
                end
            end
            mpsd_pkg::ST_SET_SPM:
            begin
                cmd.op     = mpsd_pkg::OP_SET_SPM;
                state_next = mpsd_pkg::ST_TAP_A;
            end
            mpsd_pkg::ST_TAP_A:
            begin
                cmd.op     = mpsd_pkg::OP_RDA;
                state_next = mpsd_pkg::ST_TAP_B;
            end
            mpsd_pkg::ST_TAP_B:
            begin
                cmd.op     = mpsd_pkg::OP_RDB;
                state_next = mpsd_pkg::ST_MUL1;
            end
            mpsd_pkg::ST_MUL1:
            begin
                cmd.op     = mpsd_pkg::OP_MUL1;
                state_next = mpsd_pkg::ST_MUL2;
            end
            mpsd_pkg::ST_MUL2:
            begin
                cmd.op     = mpsd_pkg::OP_MUL2;
                state_next = mpsd_pkg::ST_MUL3;
            end
            mpsd_pkg::ST_MUL3:
            begin
                cmd.op     = mpsd_pkg::OP_MUL3;
                state_next = mpsd_pkg::ST_ACC;
            end
            mpsd_pkg::ST_ACC:
            begin
                cmd.op     = mpsd_pkg::OP_ACC;
                state_next = status.tap_last ? mpsd_pkg::ST_FIN1 : mpsd_pkg::ST_TAP_A;
            end
            mpsd_pkg::ST_FIN1:
            begin
                cmd.op     = mpsd_pkg::OP_FIN1;
                state_next = mpsd_pkg::ST_FIN2;
            end
            mpsd_pkg::ST_FIN2:
            begin
                cmd.op     = mpsd_pkg::OP_FIN2;
                state_next = mpsd_pkg::ST_FIN3;
            end
            mpsd_pkg::ST_FIN3:
            begin
                cmd.op     = mpsd_pkg::OP_FIN3;
                state_next = mpsd_pkg::ST_DIV_NRP;
            end
            mpsd_pkg::ST_DIV_NRP:
            begin
                cmd.op = mpsd_pkg::OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = mpsd_pkg::ST_SET_RP;
                end
            end
            mpsd_pkg::ST_SET_RP:
            begin
                cmd.op     = mpsd_pkg::OP_SET_RP;
                state_next = mpsd_pkg::ST_EMIT;
            end
            mpsd_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = mpsd_pkg::OP_OUT_LOAD;
                    state_next = mpsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/mpsd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsd_datapath
// Config registers, delay line memory, remainder unit, tap MAC, output reg.
// ----------------------------------------------------------------------------
module mpsd_datapath #(
    parameter int LINE_DEPTH = mpsd_pkg::LINE_DEPTH_DEF,
    parameter int MAX_TAPS   = mpsd_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire mpsd_pkg::cmd_t                        cmd,
    output mpsd_pkg::status_t                          status,
    input  wire logic                                  cfg_we,
    input  wire logic [mpsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mpsd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic signed [mpsd_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [mpsd_pkg::SAMPLE_W-1:0]       sample_out
);

    localparam int AW   = $clog2(LINE_DEPTH);
    localparam int LENW = AW + 1;
    localparam int DW   = (AW + 1 > mpsd_pkg::TS_W) ? AW + 1 : mpsd_pkg::TS_W;
    localparam int DCW  = $clog2(DW);
    localparam int TCW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PW   = 60;
    localparam int ACCW = PW + TCW + 1;
    localparam int SW   = ACCW - 16;
    localparam int MW   = SW + 17;
    localparam int FW   = MW + 1;
    localparam int SH   = 39;

    localparam logic signed [FW-1:0]   BIAS_SH = (FW'(1) <<< SH) - FW'(1);
    localparam logic signed [FW-1:0]   SAT_HI  = FW'(32767);
    localparam logic signed [FW-1:0]   SAT_LO  = -FW'(32768);
    localparam logic signed [ACCW-1:0] BIAS_16 = ACCW'(16'hFFFF);

    function automatic logic signed [15:0] trunc_sat(input logic signed [FW-1:0] v);
        logic signed [FW-1:0] t;
        t = v + (v[FW-1] ? BIAS_SH : '0);
        t = t >>> SH;
        if (t > SAT_HI)
            return 16'sh7FFF;
        else if (t < SAT_LO)
            return -16'sh8000;
        else
            return t[15:0];
    endfunction

    logic [mpsd_pkg::LL_W-1:0] ll_reg;
    logic [mpsd_pkg::TS_W-1:0] ts_reg;
    logic [mpsd_pkg::TC_W-1:0] tc_reg;
    logic [mpsd_pkg::RS_W-1:0] rs_reg;
    logic [mpsd_pkg::ES_W-1:0] es_reg;
    logic signed [mpsd_pkg::FG_W-1:0] fg_reg;
    logic [mpsd_pkg::OS_W-1:0] os_reg;

    logic [LENW-1:0] len;
    logic [LENW-1:0] len_m1;
    logic [LENW-1:0] thr;
    logic [TCW-1:0]  taps_m1;

    logic [DW-1:0]   div_dvd_reg;
    logic [LENW-1:0] div_rem_reg;
    logic [DCW-1:0]  div_cnt_reg;
    logic [LENW:0]   div_trial;
    logic [LENW-1:0] div_rem_next;

    logic [DW-1:0]     rp_int_reg;
    logic [15:0]       rp_frac_reg;
    logic [DW+15:0]    rp_sum;
    logic [AW-1:0]     wi_reg;
    logic [LENW-1:0]   wi_inc;
    logic [AW-1:0]     spm_reg;
    logic [AW-1:0]     k_reg;
    logic [AW-1:0]     kb;
    logic [LENW-1:0]   k_sum;
    logic [TCW-1:0]    i_reg;
    logic [AW-1:0]     clr_reg;

    logic signed [15:0]            x_reg;
    logic signed [15:0]            a_reg;
    logic signed [16:0]            diff;
    logic signed [33:0]            prod1_reg;
    logic [LENW-1:0]               e;
    logic [LENW-1:0]               tap_dist;
    logic [LENW+mpsd_pkg::ES_W-1:0] w_reg;
    logic signed [33:0]            interp_reg;
    logic [mpsd_pkg::ES_W-1:0]     wsat_reg;
    logic signed [PW-1:0]          prod2_reg;
    logic signed [ACCW-1:0]        acc_reg;
    logic signed [ACCW-1:0]        acc_bias;
    logic signed [SW-1:0]          s24_reg;
    logic signed [MW-1:0]          mfb_reg;
    logic signed [MW-1:0]          my_reg;
    logic signed [FW-1:0]          fb_sum;
    logic signed [15:0]            fb;
    logic signed [15:0]            y_reg;
    logic                          out_valid_reg;
    logic signed [15:0]            out_data_reg;

    logic signed [15:0] mem [LINE_DEPTH];
    logic signed [15:0] rdata_reg;
    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [15:0] wdata;
    logic [AW-1:0]      raddr;

    always_comb
    begin
        if (ll_reg < mpsd_pkg::LL_W'(2))
            len = LENW'(2);
        else if (32'(ll_reg) > LINE_DEPTH)
            len = LENW'(LINE_DEPTH);
        else
            len = LENW'(ll_reg);
        len_m1 = len - LENW'(1);
        thr    = len_m1 - (len >> 1);
        if (tc_reg == '0)
            taps_m1 = '0;
        else if (32'(tc_reg) > MAX_TAPS)
            taps_m1 = TCW'(MAX_TAPS - 1);
        else
            taps_m1 = TCW'(tc_reg - mpsd_pkg::TC_W'(1));
    end

    // remainder unit, one bit a step
    assign div_trial    = {div_rem_reg, div_dvd_reg[DW-1]};
    assign div_rem_next = (div_trial >= {1'b0, len}) ? LENW'(div_trial - {1'b0, len})
                                                     : LENW'(div_trial);

    assign kb     = (LENW'(k_reg) == len_m1) ? '0 : k_reg + AW'(1);
    assign raddr  = (cmd.op == mpsd_pkg::OP_RDB) ? kb : k_reg;
    assign diff   = {rdata_reg[15], rdata_reg} - {a_reg[15], a_reg};
    assign k_sum  = LENW'(k_reg) + LENW'(spm_reg);
    assign wi_inc = LENW'(wi_reg) + LENW'(1);
    assign rp_sum = {rp_int_reg, rp_frac_reg} + (DW + 16)'(rs_reg);
    assign acc_bias = acc_reg + (acc_reg[ACCW-1] ? BIAS_16 : '0);
    assign fb_sum = ({{(FW-16){x_reg[15]}}, x_reg} <<< SH) + FW'(mfb_reg);
    assign fb     = trunc_sat(fb_sum);

    always_comb
    begin
        if (k_reg >= wi_reg)
            e = LENW'(k_reg) - LENW'(wi_reg);
        else
            e = LENW'(k_reg) + len - LENW'(wi_reg);
        tap_dist = (e >= thr) ? len_m1 - e : e;
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = wi_reg;
        wdata = fb;
        if (cmd.op == mpsd_pkg::OP_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (cmd.op == mpsd_pkg::OP_FIN3)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ll_reg <= mpsd_pkg::LL_RST;
            ts_reg <= mpsd_pkg::TS_RST;
            tc_reg <= mpsd_pkg::TC_RST;
            rs_reg <= mpsd_pkg::RS_RST;
            es_reg <= mpsd_pkg::ES_RST;
            fg_reg <= mpsd_pkg::FG_RST;
            os_reg <= mpsd_pkg::OS_RST;
        end
        else if (cfg_we)
        begin
            unique case (mpsd_pkg::cfg_idx_t'(cfg_index))
                mpsd_pkg::CFG_LINE_LENGTH:    ll_reg <= cfg_data[mpsd_pkg::LL_W-1:0];
                mpsd_pkg::CFG_TAP_SPACING:    ts_reg <= cfg_data[mpsd_pkg::TS_W-1:0];
                mpsd_pkg::CFG_TAP_COUNT:      tc_reg <= cfg_data[mpsd_pkg::TC_W-1:0];
                mpsd_pkg::CFG_READ_STEP:      rs_reg <= cfg_data[mpsd_pkg::RS_W-1:0];
                mpsd_pkg::CFG_ENVELOPE_SLOPE: es_reg <= cfg_data[mpsd_pkg::ES_W-1:0];
                mpsd_pkg::CFG_FEEDBACK_GAIN:  fg_reg <= cfg_data[mpsd_pkg::FG_W-1:0];
                mpsd_pkg::CFG_OUTPUT_SCALE:   os_reg <= cfg_data[mpsd_pkg::OS_W-1:0];
                default:                      ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            rp_int_reg    <= '0;
            rp_frac_reg   <= '0;
            wi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == mpsd_pkg::OP_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.op == mpsd_pkg::OP_START && LENW'(wi_reg) >= len)
            begin
                wi_reg <= '0;
            end
            if (cmd.op == mpsd_pkg::OP_SET_RPI || cmd.op == mpsd_pkg::OP_SET_RP)
            begin
                rp_int_reg <= DW'(div_rem_reg);
            end
            if (cmd.op == mpsd_pkg::OP_FIN3)
            begin
                wi_reg      <= (wi_inc >= len) ? '0 : wi_inc[AW-1:0];
                rp_frac_reg <= rp_sum[15:0];
            end
            if (cmd.op == mpsd_pkg::OP_OUT_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            mpsd_pkg::OP_START:
            begin
                x_reg       <= sample_in;
                div_dvd_reg <= rp_int_reg;
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
            end
            mpsd_pkg::OP_DIV_STEP:
            begin
                div_dvd_reg <= div_dvd_reg << 1;
                div_rem_reg <= div_rem_next;
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
            mpsd_pkg::OP_SET_RPI:
            begin
                div_dvd_reg <= DW'(ts_reg);
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
            end
            mpsd_pkg::OP_SET_SPM:
            begin
                spm_reg <= div_rem_reg[AW-1:0];
                k_reg   <= rp_int_reg[AW-1:0];
                i_reg   <= '0;
                acc_reg <= '0;
            end
            mpsd_pkg::OP_RDB:
            begin
                a_reg <= rdata_reg;
            end
            mpsd_pkg::OP_MUL1:
            begin
                prod1_reg <= $signed({1'b0, rp_frac_reg}) * diff;
                w_reg     <= tap_dist * es_reg;
            end
            mpsd_pkg::OP_MUL2:
            begin
                interp_reg <= {{2{a_reg[15]}}, a_reg, 16'h0000} + prod1_reg;
                wsat_reg   <= (w_reg > (LENW + mpsd_pkg::ES_W)'(mpsd_pkg::WEIGHT_MAX))
                              ? mpsd_pkg::WEIGHT_MAX : w_reg[mpsd_pkg::ES_W-1:0];
            end
            mpsd_pkg::OP_MUL3:
            begin
                prod2_reg <= interp_reg * $signed({1'b0, wsat_reg});
            end
            mpsd_pkg::OP_ACC:
            begin
                acc_reg <= acc_reg + ACCW'(prod2_reg);
                k_reg   <= (k_sum >= len) ? AW'(k_sum - len) : k_sum[AW-1:0];
                i_reg   <= i_reg + TCW'(1);
            end
            mpsd_pkg::OP_FIN1:
            begin
                s24_reg <= SW'(acc_bias >>> 16);
            end
            mpsd_pkg::OP_FIN2:
            begin
                mfb_reg <= MW'(s24_reg * fg_reg);
                my_reg  <= s24_reg * $signed({1'b0, os_reg});
            end
            mpsd_pkg::OP_FIN3:
            begin
                y_reg       <= trunc_sat(FW'(my_reg));
                div_dvd_reg <= rp_sum[DW+15:16];
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
            end
            mpsd_pkg::OP_OUT_LOAD:
            begin
                out_data_reg <= y_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.clear_last = (clr_reg == AW'(LINE_DEPTH - 1));
    assign status.div_last   = (div_cnt_reg == DCW'(DW - 1));
    assign status.tap_last   = (i_reg == taps_m1);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule
`default_nettype wire

/* sv/mpsd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsd_checker
// Port-level checks of the multitap pitch shift delay.
// ----------------------------------------------------------------------------
module mpsd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] sample_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample_out))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while busy");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall, 1) && $past(in_stall, 2))
        else $error("result without a busy phase");

endmodule

bind multitap_pitch_shift_delay mpsd_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
);
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multitap pitch shift delay. Samples are pushed
// through the block under several register settings and each output sample
// is compared with a bit-accurate software model of the delay line and taps.
// ----------------------------------------------------------------------------
module tb;
    import mpsd_pkg::*;

    localparam int DEPTH  = LINE_DEPTH_DEF;
    localparam int NTAPS  = MAX_TAPS_DEF;
    localparam int LIMIT  = 3000000;
    localparam int NDIR   = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    multitap_pitch_shift_delay dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
        .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model state
    logic [LL_W-1:0] m_len = LL_RST;
    logic [TS_W-1:0] m_spacing = TS_RST;
    logic [TC_W-1:0] m_taps = TC_RST;
    logic [RS_W-1:0] m_step = RS_RST;
    logic [ES_W-1:0] m_slope = ES_RST;
    logic signed [FG_W-1:0] m_fb = FG_RST;
    logic [OS_W-1:0] m_scale = OS_RST;
    logic signed [15:0] m_line [DEPTH];
    longint unsigned m_wr = 0;
    longint unsigned m_rp = 0;

    logic signed [15:0] pending_out [$];
    int errors = 0;
    int cycles = 0;
    int accepted = 0;

    function automatic longint trunc_sh(longint v, int n);
        if (v < 0)
            return -((-v) >>> n);
        return v >>> n;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic signed [15:0] shift_sample(logic signed [15:0] x_in);
        longint unsigned len, taps, span, half, pos, k, e, tap_dist, w;
        longint f, a, b, interp, acc, s24, fbv, y;
        len = m_len;
        taps = m_taps;
        acc = 0;
        if (len < 2) len = 2;
        if (len > DEPTH) len = DEPTH;
        if (taps < 1) taps = 1;
        if (taps > NTAPS) taps = NTAPS;
        span = len << 16;
        half = len / 2;
        m_rp = m_rp % span;
        if (m_wr >= len) m_wr = 0;
        for (longint unsigned i = 0; i < taps; i++)
        begin
            pos = (m_rp + ((i * m_spacing) << 16)) % span;
            k = pos >> 16;
            f = longint'(pos & 64'hFFFF);
            a = m_line[k];
            b = (k == len - 1) ? m_line[0] : m_line[k + 1];
            interp = a * 65536 + f * (b - a);
            e = (k >= m_wr) ? k - m_wr : k + len - m_wr;
            tap_dist = (e >= len - 1 - half) ? (len - 1 - e) : e;
            w = tap_dist * m_slope;
            if (w > 64'd16777216) w = 16777216;
            acc += interp * longint'(w);
        end
        s24 = trunc_sh(acc, 16);
        fbv = clamp16(trunc_sh(longint'(x_in) * (longint'(1) << 39)
                               + s24 * longint'(m_fb), 39));
        y = clamp16(trunc_sh(s24 * longint'(m_scale), 39));
        m_rp = (m_rp + m_step) % span;
        m_line[m_wr] = 16'(fbv);
        m_wr++;
        if (m_wr >= len) m_wr = 0;
        return 16'(y);
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LINE_LENGTH:    m_len = val[LL_W-1:0];
            CFG_TAP_SPACING:    m_spacing = val[TS_W-1:0];
            CFG_TAP_COUNT:      m_taps = val[TC_W-1:0];
            CFG_READ_STEP:      m_step = val[RS_W-1:0];
            CFG_ENVELOPE_SLOPE: m_slope = val[ES_W-1:0];
            CFG_FEEDBACK_GAIN:  m_fb = val[FG_W-1:0];
            CFG_OUTPUT_SCALE:   m_scale = val[OS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // one request; known gives a typed-in expected output
    task automatic send_sample(logic signed [15:0] x, bit known, logic signed [15:0] want);
        logic signed [15:0] model_out;
        sample_in <= x;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        model_out = shift_sample(x);
        if (known && model_out !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch: typed %0d model %0d", want, model_out);
        end
        pending_out.push_back(model_out);
        accepted++;
    endtask

    task automatic send_run(int n, int lo, int hi);
        int burst;
        int gap;
        logic signed [15:0] x;
        while (n > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0)
            begin
                case ($urandom_range(0, 5))
                    0: x = 16'sh7FFF;
                    1: x = 16'sh8000;
                    default: x = 16'($urandom_range(hi - lo) + lo);
                endcase
                send_sample(x, 1'b0, '0);
                burst--;
                n--;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    typedef struct {
        logic signed [15:0] x;
        bit known;
        logic signed [15:0] want;
    } row_t;

    row_t stim_table [NDIR] = '{
        '{16'sh7FFF, 1'b1, 16'sd0}, '{16'sh8000, 1'b1, 16'sd0},
        '{16'sd0, 1'b1, 16'sd0}, '{16'sd1, 1'b1, 16'sd0},
        '{-16'sd1, 1'b1, 16'sd0}, '{16'sh5555, 1'b1, 16'sd0},
        '{16'shAAAA, 1'b0, 16'sd0}, '{16'sh7FFF, 1'b0, 16'sd0},
        '{16'sh7FFF, 1'b0, 16'sd0}, '{16'sh8000, 1'b0, 16'sd0},
        '{16'sh1234, 1'b0, 16'sd0}, '{-16'sd1234, 1'b0, 16'sd0},
        '{16'sh7FFF, 1'b0, 16'sd0}, '{16'sh0F0F, 1'b0, 16'sd0},
        '{16'shF0F0, 1'b0, 16'sd0}, '{16'sh8000, 1'b0, 16'sd0}
    };

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
            out_stall <= ($urandom_range(0, 255) < 64) ? ($urandom_range(0, 2) != 0) : 1'b0;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output sample %0d", sample_out);
            end
            else
            begin
                if (sample_out !== pending_out[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("sample_out mismatch: expected %0d actual %0d",
                                 pending_out[0], sample_out);
                end
                void'(pending_out.pop_front());
            end
        end
        if (cycles > LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            m_line[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero line after reset, then extremes through default taps
        for (int r = 0; r < NDIR; r++)
            send_sample(stim_table[r].x, stim_table[r].known, stim_table[r].want);
        in_valid <= 1'b0;
        drain();

        // short line, heavy feedback, full output gain, full weight
        write_reg(CFG_LINE_LENGTH, 25'd8);
        write_reg(CFG_TAP_SPACING, 25'd2);
        write_reg(CFG_TAP_COUNT, 25'd4);
        write_reg(CFG_READ_STEP, 25'd98304);
        write_reg(CFG_ENVELOPE_SLOPE, 25'h100_0000);
        write_reg(CFG_FEEDBACK_GAIN, 25'h8000);
        write_reg(CFG_OUTPUT_SCALE, 25'h8000);
        send_run(300, -32768, 32767);
        drain();

        // below-range length and tap count, max step, spacing beyond line
        write_reg(CFG_LINE_LENGTH, 25'd0);
        write_reg(CFG_TAP_COUNT, 25'd0);
        write_reg(CFG_READ_STEP, 25'h3FFFF);
        write_reg(CFG_TAP_SPACING, 25'd8191);
        write_reg(CFG_FEEDBACK_GAIN, 25'h7FFF);
        send_run(150, -32768, 32767);
        drain();

        // over-range taps, length above depth, minimal step and slope
        write_reg(CFG_LINE_LENGTH, 25'h3FFF);
        write_reg(CFG_TAP_COUNT, 25'hF);
        write_reg(CFG_TAP_SPACING, 25'd1);
        write_reg(CFG_READ_STEP, 25'd0);
        write_reg(CFG_ENVELOPE_SLOPE, 25'd0);
        write_reg(CFG_OUTPUT_SCALE, 25'd0);
        send_run(60, -32768, 32767);
        drain();

        // shortened line with pointers left beyond its end
        write_reg(CFG_LINE_LENGTH, 25'd37);
        write_reg(CFG_TAP_COUNT, 25'd3);
        write_reg(CFG_TAP_SPACING, 25'd12);
        write_reg(CFG_READ_STEP, 25'd70001);
        write_reg(CFG_ENVELOPE_SLOPE, 25'd906876);
        write_reg(CFG_FEEDBACK_GAIN, 25'hC000);
        write_reg(CFG_OUTPUT_SCALE, 25'd10922);
        send_run(400, -32768, 32767);
        drain();

        // random settings on short lines
        for (int ph = 0; ph < 6; ph++)
        begin
            int len;
            int taps;
            len = $urandom_range(2, 200);
            taps = $urandom_range(1, 8);
            write_reg(CFG_LINE_LENGTH, 25'(len));
            write_reg(CFG_TAP_COUNT, 25'(taps));
            write_reg(CFG_TAP_SPACING, 25'(len / taps));
            write_reg(CFG_READ_STEP, 25'($urandom_range(0, 262143)));
            write_reg(CFG_ENVELOPE_SLOPE, 25'($urandom_range(0, 33554431)));
            write_reg(CFG_FEEDBACK_GAIN, 25'($urandom_range(0, 65535)));
            write_reg(CFG_OUTPUT_SCALE, 25'($urandom_range(0, 65535)));
            send_run(140, -32768, 32767);
            drain();
        end

        while (pending_out.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_out.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
